### rtl/core/cgte_pkg.sv
// Shared types, widths and codes of the color gradient table entry block.
// No dependencies; every rtl/core module imports this package.
package cgte_pkg;

   localparam int MaxStopsDef = 8;
   localparam int MaxTable    = 4096;
   localparam int PosOne      = 65536;

   localparam int PosW    = 17;
   localparam int ColorW  = 24;
   localparam int ChanW   = 8;
   localparam int ChanCnt = 3;
   localparam int IdxW    = 12;
   localparam int TsW     = 13;
   localparam int ScW     = 4;
   localparam int SiW     = 3;
   localparam int CsrW    = 13;
   localparam int ProdW   = 30;            // position times n-1
   localparam int LaneW   = ProdW + ChanW; // channel times weight
   localparam int DivW    = LaneW + 2;     // 2v + den
   localparam int QW      = ChanW;

   typedef enum logic [0:0] {
      CSR_TABLE_SIZE = 1'b0,
      CSR_STOP_COUNT = 1'b1
   } csr_index_type;

   typedef enum logic [0:0] {
      KIND_WRITE_STOP = 1'b0,
      KIND_READ_ENTRY = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type              kind;
      logic [SiW-1:0]        stop_index;
      logic [ColorW-1:0]     stop_color;
      logic [PosW-1:0]       stop_position;
      logic [IdxW-1:0]       entry_index;
   } req_type;

   typedef struct packed {
      logic [ColorW-1:0]     entry_color;
      logic                  entry_defined;
   } rsp_type;

   typedef struct packed {
      logic [ColorW-1:0]     color;
      logic [PosW-1:0]       pos;
   } stop_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_MUL_A,
      ST_MUL_B,
      ST_MUL_C,
      ST_MUL_D,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   function automatic logic [PosW-1:0] clamp_pos(input logic [PosW-1:0] p);
      if (int'(p) > PosOne) begin
         return PosW'(PosOne);
      end
      return p;
   endfunction

endpackage

### rtl/core/cgte_stop_mem.sv
// Color stop storage: one synchronous memory, one write and one read port.
// Read data is registered. Depends on cgte_pkg.
module cgte_stop_mem
   import cgte_pkg::*;
#(
   parameter int MaxStops = MaxStopsDef,
   localparam int SW = (MaxStops > 1) ? $clog2(MaxStops) : 1
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [SW-1:0] wr_addr,
   input  stop_type      wr_data,
   input  logic [SW-1:0] rd_addr,
   output stop_type      rd_data
);

   stop_type mem [MaxStops];
   stop_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/cgte_div.sv
// Restoring divider, three channel lanes sharing one divisor, one quotient
// bit per cycle. Depends on cgte_pkg.
module cgte_div
   import cgte_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  div_ctrl_type      ctrl,
   input  logic [DivW-1:0]   dividend [ChanCnt],
   input  logic [DivW-1:0]   divisor,
   output div_stat_type      stat,
   output logic [QW-1:0]     quot [ChanCnt]
);

   localparam int CntW = $clog2(QW);

   logic [DivW-1:0] rem_ff [ChanCnt];
   logic [QW-1:0]   q_ff   [ChanCnt];
   logic [DivW-1:0] dsh_ff;
   logic [CntW-1:0] cnt_ff;
   logic            busy_ff;
   logic            done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == CntW'(QW - 1));
         if (ctrl.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CntW'(QW - 1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         dsh_ff <= divisor << (QW - 1);
         for (int c = 0; c < ChanCnt; c++) begin
            rem_ff[c] <= dividend[c];
            q_ff[c]   <= '0;
         end
      end else if (busy_ff) begin
         dsh_ff <= dsh_ff >> 1;
         for (int c = 0; c < ChanCnt; c++) begin
            if (rem_ff[c] >= dsh_ff) begin
               rem_ff[c] <= rem_ff[c] - dsh_ff;
               q_ff[c]   <= {q_ff[c][QW-2:0], 1'b1};
            end else begin
               q_ff[c]   <= {q_ff[c][QW-2:0], 1'b0};
            end
         end
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quot      = q_ff;

endmodule

### rtl/core/color_gradient_table_entry.sv
// Channel | dir | payload  | beat taken when
// req     | in  | req_type | req_valid && !req_stall
// rsp     | out | rsp_type | rsp_valid && !rsp_stall
// csr     | in  | 13 bits  | csr_we
// A stop write is taken in the idle state. An entry beat goes straight to output when
// undefined, else reads and checks stops in turn (memory read, then boundary multiply
// and compare), and adds the multiply states and the divider (8 steps, then done)
// when it interpolates.
// Reset is synchronous; the stop memory has no reset and needs no clear pass.
// A held result in rsp does not block req; a finished entry waits on rsp_stall.
module color_gradient_table_entry
   import cgte_pkg::*;
#(
   parameter int MaxStops = MaxStopsDef
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_type       req_data,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_data,
   input  logic          csr_we,
   input  csr_index_type csr_index,
   input  logic [CsrW-1:0] csr_wdata
);

   localparam int SW = (MaxStops > 1) ? $clog2(MaxStops) : 1;
   localparam int CW = $clog2(MaxStops + 1);

   state_type state_ff, state_in;

   logic [TsW-1:0]    ts_ff;
   logic [ScW-1:0]    sc_ff;
   logic [SW-1:0]     k_ff;
   logic [CW-1:0]     s_ff;
   logic [IdxW-1:0]   idx_ff;
   logic [TsW-1:0]    nm1_ff;
   logic [ColorW-1:0] prev_col_ff, cur_col_ff, color_ff;
   logic [PosW-1:0]   prev_pos_ff, cur_pos_ff;
   logic [ProdW-1:0]  prod_ff, num_ff, den_ff;
   logic [LaneW-1:0]  lane_ff [ChanCnt];
   logic              def_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;

   logic              req_accept, mem_wr_en, undef_in, hit, last, blend_skip;
   logic [TsW-1:0]    n_eff;
   logic [CW-1:0]     s_eff;
   logic [PosW-1:0]   chk_pos;
   logic [ProdW-1:0]  bprod;
   logic [ProdW:0]    bsum;
   logic [ProdW-16:0] bound;
   logic              out_load;
   stop_type          mem_wr_data, mem_rd_data;
   div_ctrl_type      div_ctrl;
   div_stat_type      div_stat;
   logic [DivW-1:0]   dividend [ChanCnt];
   logic [DivW-1:0]   divisor;
   logic [QW-1:0]     quot [ChanCnt];

   assign req_accept = req_valid && !req_stall;

   always_comb begin
      n_eff = (int'(ts_ff) > MaxTable) ? TsW'(MaxTable) : ts_ff;
      s_eff = (int'(sc_ff) > MaxStops) ? CW'(MaxStops) : CW'(sc_ff);
      undef_in = (s_eff == '0) || ({1'b0, req_data.entry_index} >= n_eff);
   end

   // boundary of the stop being checked: ceil(pos * (n-1) / 65536)
   always_comb begin
      chk_pos = clamp_pos(mem_rd_data.pos);
      bprod   = ProdW'(chk_pos * nm1_ff);
      bsum    = {1'b0, bprod} + (ProdW + 1)'(PosOne - 1);
      bound   = bsum[ProdW:16];
      hit     = (ProdW - 15)'(idx_ff) < bound;
      last    = CW'(k_ff) == (s_ff - CW'(1));
      blend_skip = (den_ff == '0) || (num_ff > den_ff);
   end

   assign out_load = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_data.kind == KIND_READ_ENTRY) begin
               state_in = undef_in ? ST_OUT : ST_READ;
            end
         end
         ST_READ:  state_in = ST_CHECK;
         ST_CHECK: begin
            priority if (hit) begin
               state_in = (k_ff == '0) ? ST_OUT : ST_MUL_A;
            end else if (last) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_MUL_A: state_in = ST_MUL_B;
         ST_MUL_B: state_in = ST_MUL_C;
         ST_MUL_C: state_in = blend_skip ? ST_OUT : ST_MUL_D;
         ST_MUL_D: state_in = ST_DIV;
         ST_DIV:   state_in = div_stat.done ? ST_OUT : ST_DIV;
         ST_OUT:   state_in = out_load ? ST_IDLE : ST_OUT;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_stall      = (state_ff != ST_IDLE);
      div_ctrl.start = (state_ff == ST_MUL_D);
      mem_wr_en      = req_accept && (req_data.kind == KIND_WRITE_STOP)
                       && (int'(req_data.stop_index) < MaxStops);
   end

   assign mem_wr_data.color = req_data.stop_color;
   assign mem_wr_data.pos   = req_data.stop_position;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ts_ff        <= TsW'(256);
         sc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_TABLE_SIZE: ts_ff <= csr_wdata;
               CSR_STOP_COUNT: sc_ff <= csr_wdata[ScW-1:0];
               default: ;
            endcase
         end
         if (state_ff == ST_OUT && out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            idx_ff <= req_data.entry_index;
            nm1_ff <= n_eff - TsW'(1);
            s_ff   <= s_eff;
            k_ff   <= '0;
            color_ff <= '0;
            def_ff   <= 1'b0;
         end
         ST_CHECK: begin
            priority if (hit) begin
               cur_col_ff <= mem_rd_data.color;
               cur_pos_ff <= chk_pos;
               if (k_ff == '0) begin
                  color_ff <= mem_rd_data.color;
                  def_ff   <= 1'b1;
               end
            end else begin
               prev_col_ff <= mem_rd_data.color;
               prev_pos_ff <= chk_pos;
               if (last) begin
                  color_ff <= mem_rd_data.color;
                  def_ff   <= 1'b1;
               end else begin
                  k_ff <= k_ff + 1'b1;
               end
            end
         end
         ST_MUL_A: prod_ff <= ProdW'(prev_pos_ff * nm1_ff);
         ST_MUL_B: begin
            num_ff <= ProdW'({idx_ff, 16'b0}) - prod_ff;
            den_ff <= ProdW'((cur_pos_ff - prev_pos_ff) * nm1_ff);
         end
         ST_MUL_C: begin
            if (blend_skip) begin
               color_ff <= prev_col_ff;
               def_ff   <= 1'b1;
            end
            for (int c = 0; c < ChanCnt; c++) begin
               lane_ff[c] <= LaneW'(prev_col_ff[c*ChanW +: ChanW] * (den_ff - num_ff));
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               color_ff <= {quot[2], quot[1], quot[0]};
               def_ff   <= 1'b1;
            end
         end
         ST_OUT: begin
            if (out_load) begin
               rsp_data_ff.entry_color   <= color_ff;
               rsp_data_ff.entry_defined <= def_ff;
            end
         end
         default: ;
      endcase
   end

   // 2v + den per lane, v = a*(den-num) + b*num
   always_comb begin
      for (int c = 0; c < ChanCnt; c++) begin
         dividend[c] = {(lane_ff[c]
                         + LaneW'(cur_col_ff[c*ChanW +: ChanW] * num_ff)), 1'b0}
                       + DivW'(den_ff);
      end
      divisor = DivW'({den_ff, 1'b0});
   end

   cgte_stop_mem #(
      .MaxStops (MaxStops)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (SW'(req_data.stop_index)),
      .wr_data (mem_wr_data),
      .rd_addr (k_ff),
      .rd_data (mem_rd_data)
   );

   cgte_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (dividend),
      .divisor  (divisor),
      .stat     (div_stat),
      .quot     (quot)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_k_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CHECK |-> CW'(k_ff) < s_ff)
      else $error("stop scan ran past stop count");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> state_ff == ST_DIV)
      else $error("divider finished outside divide state");

   a_write_no_work: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_data.kind == KIND_WRITE_STOP |=> state_ff == ST_IDLE)
      else $error("stop write started entry work");

   a_undef_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.entry_defined |-> rsp_data_ff.entry_color == '0)
      else $error("undefined entry carries a color");

endmodule
